>>> rtl/assert_macros.svh
// assertion macros for the lexer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define CSL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked at every rising clock edge outside reset
`define CSL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/csl_pkg.sv
// types, constants and keyword table for the c subset lexer
// no dependencies; imported by csl_step and c_subset_lexer_top
`default_nettype none

package csl_pkg;

   localparam int OFFSET_BITS  = 16;
   localparam int VALUE_BITS   = 32;
   localparam int PREFIX_DEPTH = 6;
   localparam int PIDX_BITS    = $clog2(PREFIX_DEPTH);
   localparam int KW_COUNT     = 7;
   localparam int KW_IDX_BITS  = 3;
   localparam int KW_LEN_BITS  = 3;
   localparam int KIND_BITS    = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // token kind codes
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_PUNCT   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_KEYWORD = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_ERROR   = 3'd5;

   // characters with a role of their own
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_UNDER = 8'h5f;

   // keyword spellings, zero padded, and their lengths
   localparam logic [7:0] KW_TEXT [KW_COUNT][PREFIX_DEPTH] = '{
      '{"r", "e", "t", "u", "r", "n"},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"_", "B", "o", "o", "l", 8'h00}
   };
   localparam logic [KW_LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
      3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd5
   };

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_PUNCT
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   token_kind;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [OFFSET_BITS-1:0] token_length;
      logic [VALUE_BITS-1:0]  number_value;
      logic [KW_IDX_BITS-1:0] keyword_index;
      logic [7:0]             punct_char;
      logic                   last_of_run;
   } rsp_token_type;

   typedef struct packed {
      lex_mode_type           mode;
      logic [OFFSET_BITS-1:0] token_start;
      logic [OFFSET_BITS-1:0] token_len;
      logic [VALUE_BITS-1:0]  number_accum;
      logic [OFFSET_BITS-1:0] byte_position;
      logic [7:0]             pending_punct;
      logic                   error_latched;
   } lex_state_type;

   typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_type;

   typedef struct packed {
      logic                 we;
      logic [PIDX_BITS-1:0] idx;
      logic [7:0]           data;
   } pfx_write_type;

   typedef struct packed {
      logic          tok0_valid;
      logic          tok1_valid;
      rsp_token_type tok0;
      rsp_token_type tok1;
   } step_out_type;

   typedef struct packed {
      logic                   hit;
      logic [KW_IDX_BITS-1:0] idx;
   } kw_result_type;

   // keyword match on the buffered prefix and the identifier length
   function automatic kw_result_type kw_lookup(input prefix_type pfx,
                                               input logic [OFFSET_BITS-1:0] len);
      kw_result_type r;
      logic          same;
      r = '0;
      for (int i = 0; i < KW_COUNT; i++) begin
         same = (len == OFFSET_BITS'(KW_LEN[i]));
         for (int j = 0; j < PREFIX_DEPTH; j++) begin
            if ((KW_LEN_BITS'(j) < KW_LEN[i]) && (pfx[j] != KW_TEXT[i][j])) begin
               same = 1'b0;
            end
         end
         if (same && !r.hit) begin
            r.hit = 1'b1;
            r.idx = KW_IDX_BITS'(i);
         end
      end
      return r;
   endfunction

   // counter step that holds at all ones
   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + OFFSET_BITS'(1);
   endfunction

endpackage

`default_nettype wire

>>> rtl/c_subset_lexer_top.sv
// An accepted item is held in the input register and processed once the token queue has room
// for two tokens. Throughput: one item per cycle while each item gives at most one token and
// rsp_stall is low; an item giving two tokens (flush plus new token, or flush plus EOF) pushes
// both into the four-entry token queue, drained one token per cycle while rsp_stall is low.
// Reset (synchronous) clears the lexer state, the input valid flag and the token queue pointers and count.
// this file: top level with input register, lexer state and token queue; uses csl_pkg, csl_step
`default_nettype none
`include "assert_macros.svh"

module c_subset_lexer_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  csl_pkg::req_item_type  req_item,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output csl_pkg::rsp_token_type rsp_token
);
   import csl_pkg::*;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   req_item_type         in_item_ff;
   lex_state_type        state_ff;
   lex_state_type        state_in;
   prefix_type           prefix_ff;
   pfx_write_type        pfx_wr;
   step_out_type         step_out;
   rsp_token_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;
   logic [1:0]           push_n;
   logic                 fire;
   logic                 pop;
   logic                 accept;

   // handshake: process the held item when the queue has room for two tokens
   assign fire      = in_valid_ff && (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_token = queue_ff[rd_ptr_ff];

   csl_step u_step (
      .item       (in_item_ff),
      .state      (state_ff),
      .prefix     (prefix_ff),
      .state_next (state_in),
      .pfx_wr     (pfx_wr),
      .step_out   (step_out)
   );

   // queue pointer and count updates
   always_comb begin
      push_n      = fire ? (2'(step_out.tok0_valid) + 2'(step_out.tok1_valid)) : 2'd0;
      wr_ptr_in   = wr_ptr_ff + QPTR_BITS'(push_n);
      rd_ptr_in   = rd_ptr_ff + QPTR_BITS'(pop);
      count_in    = count_ff + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload registers: input item, identifier prefix, token queue
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (fire && pfx_wr.we) begin
         prefix_ff[pfx_wr.idx] <= pfx_wr.data;
      end
      if (fire && step_out.tok0_valid) begin
         queue_ff[wr_ptr_ff] <= step_out.tok0;
      end
      if (fire && step_out.tok1_valid) begin
         queue_ff[wr_ptr_ff + QPTR_BITS'(1)] <= step_out.tok1;
      end
   end

   // checks
   `CSL_ASSERT(a_queue_bound, clock, reset, (count_ff <= QCNT_BITS'(QUEUE_DEPTH)), "token queue overflow")
   `CSL_ASSERT_IMP(a_err_idle, clock, reset, state_ff.error_latched, (state_ff.mode == MODE_IDLE), "lexer busy after error")
   `CSL_ASSERT_IMP(a_pair_order, clock, reset, step_out.tok1_valid, (step_out.tok0_valid && !step_out.tok0.last_of_run), "second token without open first")
   `CSL_ASSERT(a_eof_clears, clock, reset, (fire && in_item_ff.end_of_text |=> state_ff.byte_position == '0 && state_ff.mode == MODE_IDLE), "end of text did not clear state")
   `CSL_ASSERT(a_pos_hold, clock, reset, (!fire |=> $stable(state_ff.byte_position)), "position moved without an item")

endmodule

`default_nettype wire

>>> rtl/csl_step.sv
// one lexer step: classifies the byte, builds up to two tokens, next state
// depends on csl_pkg; used by c_subset_lexer_top
`default_nettype none

module csl_step (
   input  csl_pkg::req_item_type  item,
   input  csl_pkg::lex_state_type state,
   input  csl_pkg::prefix_type    prefix,
   output csl_pkg::lex_state_type state_next,
   output csl_pkg::pfx_write_type pfx_wr,
   output csl_pkg::step_out_type  step_out
);
   import csl_pkg::*;

   logic [7:0]          c;
   logic                is_space;
   logic                is_digit;
   logic                is_first;
   logic                is_next;
   logic                is_punct;
   logic                is_pair;
   logic                cont;
   logic                pair_done;
   logic                has_flush;
   logic                begin_emits;
   logic [VALUE_BITS+3:0] acc_wide;
   logic [VALUE_BITS-1:0] acc_next;
   kw_result_type       kw;
   rsp_token_type       flush_tok;
   rsp_token_type       begin_tok;
   rsp_token_type       eof_tok;
   rsp_token_type       pair_tok;
   rsp_token_type       a_tok;
   rsp_token_type       b_tok;
   logic                a_valid;
   logic                b_valid;

   // byte classes
   assign c        = item.char_byte;
   assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
   assign is_digit = (c >= "0") && (c <= "9");
   assign is_first = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
                     || (c == CH_UNDER);
   assign is_next  = is_first || is_digit;
   assign is_punct = (c >= 8'h21) && (c <= 8'h7e) && !is_next;
   assign is_pair  = (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);

   assign cont      = ((state.mode == MODE_NUMBER) && is_digit)
                      || ((state.mode == MODE_IDENT) && is_next);
   assign pair_done = (state.mode == MODE_PUNCT) && (c == CH_EQ);
   assign has_flush = (state.mode != MODE_IDLE);
   assign begin_emits = !is_space && !is_digit && !is_first && !(is_punct && is_pair);

   // decimal accumulate, saturating: acc*10 + digit
   assign acc_wide = ({4'b0, state.number_accum} << 3) + ({4'b0, state.number_accum} << 1)
                     + (VALUE_BITS+4)'(c[3:0]);
   assign acc_next = (acc_wide[VALUE_BITS+3:VALUE_BITS] != 4'b0) ? '1
                     : acc_wide[VALUE_BITS-1:0];

   assign kw = kw_lookup(prefix, state.token_len);

   // candidate tokens
   always_comb begin
      flush_tok              = '0;
      flush_tok.start_offset = state.token_start;
      flush_tok.token_length = state.token_len;
      case (state.mode)
         MODE_NUMBER: begin
            flush_tok.token_kind   = KIND_NUMBER;
            flush_tok.number_value = state.number_accum;
         end
         MODE_IDENT: begin
            flush_tok.token_kind    = kw.hit ? KIND_KEYWORD : KIND_IDENT;
            flush_tok.keyword_index = kw.hit ? kw.idx : '0;
         end
         MODE_PUNCT: begin
            flush_tok.token_kind   = KIND_PUNCT;
            flush_tok.token_length = OFFSET_BITS'(1);
            flush_tok.punct_char   = state.pending_punct;
         end
         default: begin
            flush_tok.token_kind = KIND_IDENT;
         end
      endcase

      begin_tok              = '0;
      begin_tok.start_offset = state.byte_position;
      begin_tok.token_length = OFFSET_BITS'(1);
      begin_tok.token_kind   = is_punct ? KIND_PUNCT : KIND_ERROR;
      begin_tok.punct_char   = is_punct ? c : 8'h00;

      eof_tok              = '0;
      eof_tok.token_kind   = KIND_EOF;
      eof_tok.start_offset = state.byte_position;

      pair_tok              = '0;
      pair_tok.token_kind   = KIND_PUNCT;
      pair_tok.start_offset = state.token_start;
      pair_tok.token_length = OFFSET_BITS'(2);
      pair_tok.punct_char   = state.pending_punct;
   end

   // pick the first and second token of this item
   always_comb begin
      a_tok   = flush_tok;
      b_tok   = begin_tok;
      a_valid = 1'b0;
      b_valid = 1'b0;
      if (item.end_of_text) begin
         a_valid = !state.error_latched && has_flush;
         b_tok   = eof_tok;
         b_valid = 1'b1;
      end else if (state.error_latched || cont) begin
         a_valid = 1'b0;
      end else if (pair_done) begin
         a_tok   = pair_tok;
         a_valid = 1'b1;
      end else begin
         a_valid = has_flush;
         b_valid = begin_emits;
      end

      step_out                  = '0;
      step_out.tok0_valid       = a_valid || b_valid;
      step_out.tok1_valid       = a_valid && b_valid;
      step_out.tok0             = a_valid ? a_tok : b_tok;
      step_out.tok0.last_of_run = !(a_valid && b_valid);
      step_out.tok1             = b_tok;
      step_out.tok1.last_of_run = 1'b1;
   end

   // next lexer state and prefix write
   always_comb begin
      state_next = state;
      pfx_wr     = '0;
      pfx_wr.data = c;
      if (item.end_of_text) begin
         state_next = '0;
      end else if (!state.error_latched) begin
         state_next.byte_position = sat_inc(state.byte_position);
         if (cont) begin
            state_next.token_len = sat_inc(state.token_len);
            if (state.mode == MODE_NUMBER) begin
               state_next.number_accum = acc_next;
            end else if (state.token_len < OFFSET_BITS'(PREFIX_DEPTH)) begin
               pfx_wr.we  = 1'b1;
               pfx_wr.idx = state.token_len[PIDX_BITS-1:0];
            end
         end else if (pair_done) begin
            state_next.mode = MODE_IDLE;
         end else begin
            state_next.mode = MODE_IDLE;
            if (!is_space) begin
               state_next.token_start = state.byte_position;
               state_next.token_len   = OFFSET_BITS'(1);
            end
            if (is_digit) begin
               state_next.mode         = MODE_NUMBER;
               state_next.number_accum = VALUE_BITS'(c[3:0]);
            end else if (is_first) begin
               state_next.mode = MODE_IDENT;
               pfx_wr.we       = 1'b1;
               pfx_wr.idx      = '0;
            end else if (is_punct && is_pair) begin
               state_next.mode          = MODE_PUNCT;
               state_next.pending_punct = c;
            end else if (!is_space && !is_punct) begin
               state_next.error_latched = 1'b1;
            end
         end
      end else begin
         state_next.byte_position = sat_inc(state.byte_position);
      end
   end

endmodule

`default_nettype wire
